// ===== rtl/fpdt_pkg.sv =====
// shared types, constants and helpers for the fixed-point to decimal text formatter
package fpdt_pkg;

	localparam int VALUE_W   = 33;
	localparam int NUM_W     = 20;
	localparam int REM_W     = 17;
	localparam int DIGIT_CELLS = 5;
	localparam int CELL_WEIGHT = 10000;
	localparam int PADDR_W   = 3;

	localparam logic [0:0] REG_FORMAT_MODE = 1'b0;

	localparam logic signed [VALUE_W-1:0] M0_MAX = 33'sd9999;
	localparam logic signed [VALUE_W-1:0] M0_MIN = -33'sd9999;
	localparam logic signed [VALUE_W-1:0] M1_MAX = 33'sd4500;
	localparam logic signed [VALUE_W-1:0] M2_MAX = 33'sd255999;

	localparam logic [27:0]      SCALE_MUL   = 28'd1000;
	localparam logic [NUM_W-1:0] ROUND_HALF  = 20'd5;
	localparam logic [NUM_W-1:0] RECIP_TEN   = 20'hCCCCD;
	localparam int               RECIP_SHIFT = 23;
	localparam logic [REM_W-1:0] FULL_SCALE  = 17'd99999;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_NONE  = 8'h00;

	localparam logic [2:0] LEN_SHORT = 3'd5;
	localparam logic [2:0] LEN_FULL  = 3'd6;

	typedef enum logic [1:0] {
		FMT_THOUSANDTHS = 2'd0,
		FMT_HUNDREDTHS  = 2'd1,
		FMT_BINARY      = 2'd2
	} fmt_t;

	typedef struct packed {
		fmt_t fmt;
		logic ovf;
		logic neg;
	} info_t;

	typedef struct packed {
		logic [REM_W-1:0]                rem;
		logic [DIGIT_CELLS-1:0][3:0]     digits;
		info_t                           info;
	} cell_data_t;

	function automatic logic [7:0] ascii_digit(input logic [3:0] d);
		ascii_digit = CH_ZERO + {4'b0000, d};
	endfunction

endpackage

// ===== rtl/fixed_point_to_decimal_text_top.sv =====
// Fixed-point to decimal text formatter. Each accepted word is one value and gives one
// word of up to six ASCII characters, in the format chosen by format_mode (register 0 at
// byte address 0): 0 signed thousandths " d.ddd", 1 unsigned hundredths " dd.dd", 2 or 3
// unsigned 1/256 binary "ddd.dd" rounded to hundredths; out-of-range values give stars.
// A new word is taken every cycle while not stalled; each passes two front stages
// (range check, the x1000/256 rescale, then a reciprocal divide by ten for rounding), a
// chain of five digit cells that each peel one decimal digit, and the output register.
// Stalls propagate back through the chain only as far as the first empty stage.
module fixed_point_to_decimal_text_top import fpdt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [PADDR_W-1:0]        paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                text_0,
	output logic [7:0]                text_1,
	output logic [7:0]                text_2,
	output logic [7:0]                text_3,
	output logic [7:0]                text_4,
	output logic [7:0]                text_5,
	output logic [2:0]                text_length
);

	logic [1:0]  format_mode_q;
	logic        in_ready;
	logic        chain_valid [0:DIGIT_CELLS];
	logic        chain_ready [0:DIGIT_CELLS];
	cell_data_t  chain_data  [0:DIGIT_CELLS];

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_mode_q <= FMT_THOUSANDTHS;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_FORMAT_MODE) begin
			format_mode_q <= pwdata[1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_FORMAT_MODE) begin
			prdata = {30'b0, format_mode_q};
		end
	end

	assign in_stall = !in_ready;

	fpdt_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.mode      (format_mode_q),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_data  (chain_data[0])
	);

	for (genvar i = 0; i < DIGIT_CELLS; i++) begin : g_cell
		fpdt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_data   (chain_data[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	fpdt_fmt u_fmt (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (chain_valid[DIGIT_CELLS]),
		.in_ready    (chain_ready[DIGIT_CELLS]),
		.in_data     (chain_data[DIGIT_CELLS]),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.text_0      (text_0),
		.text_1      (text_1),
		.text_2      (text_2),
		.text_3      (text_3),
		.text_4      (text_4),
		.text_5      (text_5),
		.text_length (text_length)
	);

endmodule

// ===== rtl/fpdt_prep.sv =====
// front end: range check, magnitude and the binary-to-hundredths rescale with rounding
module fpdt_prep import fpdt_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [VALUE_W-1:0]  value,
	input  logic [1:0]                 mode,
	output logic                       out_valid,
	input  logic                       out_ready,
	output cell_data_t                 out_data
);

	logic             valid_s1;
	info_t            info_s1;
	logic [NUM_W-1:0] num_s1;
	logic             valid_s2;
	cell_data_t       data_s2;

	logic             ready_s1;
	logic             ready_s2;
	fmt_t             fmt_c;
	info_t            info_c;
	logic [NUM_W-1:0] num_c;
	logic [27:0]      scaled_c;
	logic [39:0]      prod_c;
	logic [NUM_W-1:0] quot_c;
	logic [REM_W-1:0] rem_c;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_comb begin
		case (mode)
			FMT_THOUSANDTHS: fmt_c = FMT_THOUSANDTHS;
			FMT_HUNDREDTHS: fmt_c = FMT_HUNDREDTHS;
			default: fmt_c = FMT_BINARY;
		endcase
	end

	always_comb begin
		scaled_c = {10'b0, value[17:0]} * SCALE_MUL;
		info_c.fmt = fmt_c;
		info_c.neg = 1'b0;
		info_c.ovf = 1'b0;
		num_c = '0;
		case (fmt_c)
			FMT_THOUSANDTHS: begin
				info_c.ovf = (value > M0_MAX) || (value < M0_MIN);
				info_c.neg = value[VALUE_W-1];
				if (!info_c.ovf) begin
					num_c = info_c.neg ? NUM_W'(-value) : NUM_W'(value);
				end
			end
			FMT_HUNDREDTHS: begin
				info_c.ovf = value[VALUE_W-1] || (value > M1_MAX);
				if (!info_c.ovf) begin
					num_c = NUM_W'(value);
				end
			end
			default: begin
				info_c.ovf = value[VALUE_W-1] || (value > M2_MAX);
				// truncated thousandths plus half a hundredth
				if (!info_c.ovf) begin
					num_c = scaled_c[27:8] + ROUND_HALF;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			info_s1 <= info_c;
			num_s1  <= num_c;
		end
	end

	// binary format: divide by ten through the reciprocal, exact below four million, and clamp; others pass on
	always_comb begin
		prod_c = {20'b0, num_s1} * {20'b0, RECIP_TEN};
		quot_c = NUM_W'(prod_c[39:RECIP_SHIFT]);
		if (info_s1.fmt == FMT_BINARY) begin
			rem_c = (quot_c > NUM_W'(FULL_SCALE)) ? FULL_SCALE : quot_c[REM_W-1:0];
		end else begin
			rem_c = num_s1[REM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			data_s2.rem    <= rem_c;
			data_s2.digits <= '0;
			data_s2.info   <= info_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

// ===== rtl/fpdt_cell.sv =====
// one digit cell: peels the leading decimal digit and passes the scaled remainder on
module fpdt_cell import fpdt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  cell_data_t in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output cell_data_t out_data
);

	logic             valid_q;
	cell_data_t       data_q;
	logic [3:0]       digit_c;
	logic [REM_W-1:0] sub_c;
	logic [REM_W-1:0] left_c;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		digit_c = 4'd0;
		sub_c   = '0;
		for (int k = 1; k <= 9; k++) begin
			if (in_data.rem >= REM_W'(k * CELL_WEIGHT)) begin
				digit_c = 4'(k);
				sub_c   = REM_W'(k * CELL_WEIGHT);
			end
		end
		left_c = in_data.rem - sub_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q.rem    <= (left_c << 3) + (left_c << 1);
			data_q.digits <= {in_data.digits[DIGIT_CELLS-2:0], digit_c};
			data_q.info   <= in_data.info;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ===== rtl/fpdt_fmt.sv =====
// output register: lays the digits out as display text
module fpdt_fmt import fpdt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  cell_data_t in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] text_0,
	output logic [7:0] text_1,
	output logic [7:0] text_2,
	output logic [7:0] text_3,
	output logic [7:0] text_4,
	output logic [7:0] text_5,
	output logic [2:0] text_length
);

	logic            valid_q;
	logic [5:0][7:0] text_q;
	logic [2:0]      len_q;
	logic [5:0][7:0] text_c;
	logic [2:0]      len_c;
	logic [3:0]      d4, d3, d2, d1, d0;

	assign in_ready = !valid_q || !out_stall;

	assign d4 = in_data.digits[4];
	assign d3 = in_data.digits[3];
	assign d2 = in_data.digits[2];
	assign d1 = in_data.digits[1];
	assign d0 = in_data.digits[0];

	always_comb begin
		text_c = '0;
		len_c  = LEN_FULL;
		case (in_data.info.fmt)
			FMT_THOUSANDTHS: begin
				if (in_data.info.ovf) begin
					text_c = {CH_NONE, CH_STAR, CH_STAR, CH_STAR, CH_DOT, CH_STAR};
					len_c  = LEN_SHORT;
				end else begin
					text_c[0] = in_data.info.neg ? CH_MINUS : CH_SPACE;
					text_c[1] = ascii_digit(d3);
					text_c[2] = CH_DOT;
					text_c[3] = ascii_digit(d2);
					text_c[4] = ascii_digit(d1);
					text_c[5] = ascii_digit(d0);
				end
			end
			FMT_HUNDREDTHS: begin
				if (in_data.info.ovf) begin
					text_c = {CH_NONE, CH_STAR, CH_STAR, CH_DOT, CH_STAR, CH_STAR};
					len_c  = LEN_SHORT;
				end else begin
					text_c[0] = CH_SPACE;
					text_c[1] = (d3 == 4'd0) ? CH_SPACE : ascii_digit(d3);
					text_c[2] = ascii_digit(d2);
					text_c[3] = CH_DOT;
					text_c[4] = ascii_digit(d1);
					text_c[5] = ascii_digit(d0);
				end
			end
			default: begin
				if (in_data.info.ovf) begin
					text_c = {CH_STAR, CH_STAR, CH_DOT, CH_STAR, CH_STAR, CH_STAR};
				end else begin
					text_c[0] = (d4 == 4'd0) ? CH_SPACE : ascii_digit(d4);
					text_c[1] = (d4 == 4'd0 && d3 == 4'd0) ? CH_SPACE : ascii_digit(d3);
					text_c[2] = ascii_digit(d2);
					text_c[3] = CH_DOT;
					text_c[4] = ascii_digit(d1);
					text_c[5] = ascii_digit(d0);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			text_q <= text_c;
			len_q  <= len_c;
		end
	end

	assign out_valid   = valid_q;
	assign text_0      = text_q[0];
	assign text_1      = text_q[1];
	assign text_2      = text_q[2];
	assign text_3      = text_q[3];
	assign text_4      = text_q[4];
	assign text_5      = text_q[5];
	assign text_length = len_q;

endmodule

// ===== rtl/fpdt_checker.sv =====
// port-level checks on the formatter, bound to the top level
module fpdt_checker import fpdt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] text_0,
	input logic [7:0] text_2,
	input logic [7:0] text_3,
	input logic [7:0] text_5,
	input logic [2:0] text_length
);

	// a held word keeps its first and fourth characters and its length
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(text_0) && $stable(text_3)
			&& $stable(text_length))
		else $error("stalled output word changed");

	a_short_is_stars: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && text_length == LEN_SHORT |-> text_0 == CH_STAR && text_5 == CH_NONE)
		else $error("short word is not an overflow string");

	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> text_length == LEN_SHORT || text_length == LEN_FULL)
		else $error("bad text length");

	// decimal point sits in the third or fourth place of a full word
	a_point: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && text_length == LEN_FULL |-> text_2 == CH_DOT || text_3 == CH_DOT)
		else $error("decimal point misplaced");

endmodule

bind fixed_point_to_decimal_text_top fpdt_checker u_fpdt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.text_0      (text_0),
	.text_2      (text_2),
	.text_3      (text_3),
	.text_5      (text_5),
	.text_length (text_length)
);
